### hw/rtl/sim_to_ht_frame_velocity_unit_assert.svh
// ----------------------------------------------------------------------------
// HT frame velocity assertion macros
// Shared concurrent check macros, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SIM_TO_HT_FRAME_VELOCITY_UNIT_ASSERT_SVH
`define SIM_TO_HT_FRAME_VELOCITY_UNIT_ASSERT_SVH

// combinational property checked at every edge
`define SHTV_ASSERT_NOW(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define SHTV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/shtv_pkg.sv
// ----------------------------------------------------------------------------
// HT frame velocity package
// Widths, latencies and register indexes shared by the transform units.
// ----------------------------------------------------------------------------
package shtv_pkg;

	// default field widths and fraction bits
	localparam int VEL_BITS_DEF  = 32;
	localparam int NFRAC_DEF     = 30;
	localparam int FIELD_BITS    = 32;
	localparam int NORM_BITS     = 32;
	localparam int OUT_BITS      = 30;
	localparam int MNF_BITS      = 20;
	localparam int LIM_BITS      = 29;
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 29;

	// normal field and tangential field widths
	localparam int BN_BITS = 34;
	localparam int BT_BITS = 35;

	// shift magnitude cap and multiplier split point
	localparam int CAP_BITS  = 41;
	localparam int MUL_SPLIT = 18;

	// pipeline depths
	localparam int FRONT_LAT = 7;
	localparam int LANE_LAT  = CAP_BITS + 4;

	// reset values
	localparam logic [MNF_BITS-1:0] MNF_RESET = 20'd100;
	localparam logic [LIM_BITS-1:0] LIM_RESET = 29'd299792458;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_MIN_NORMAL_FIELD = 1'b0,
		REG_SPEED_LIMIT      = 1'b1
	} cfg_reg_t;

endpackage

### hw/rtl/shtv_in_if.sv
// ----------------------------------------------------------------------------
// HT frame velocity input channel
// Valid/ready channel carrying plasma, field, shock velocity and normal.
// ----------------------------------------------------------------------------
interface shtv_in_if #(
	parameter int VEL_BITS = shtv_pkg::VEL_BITS_DEF
) ();
	logic valid;
	logic ready;
	logic signed [VEL_BITS-1:0] plasma_vx;
	logic signed [VEL_BITS-1:0] plasma_vy;
	logic signed [VEL_BITS-1:0] plasma_vz;
	logic signed [shtv_pkg::FIELD_BITS-1:0] field_x;
	logic signed [shtv_pkg::FIELD_BITS-1:0] field_y;
	logic signed [shtv_pkg::FIELD_BITS-1:0] field_z;
	logic signed [VEL_BITS-1:0] shock_vx;
	logic signed [VEL_BITS-1:0] shock_vy;
	logic signed [VEL_BITS-1:0] shock_vz;
	logic signed [shtv_pkg::NORM_BITS-1:0] normal_x;
	logic signed [shtv_pkg::NORM_BITS-1:0] normal_y;
	logic signed [shtv_pkg::NORM_BITS-1:0] normal_z;

	modport source (
		output valid, plasma_vx, plasma_vy, plasma_vz, field_x, field_y, field_z,
		output shock_vx, shock_vy, shock_vz, normal_x, normal_y, normal_z,
		input ready
	);
	modport sink (
		input valid, plasma_vx, plasma_vy, plasma_vz, field_x, field_y, field_z,
		input shock_vx, shock_vy, shock_vz, normal_x, normal_y, normal_z,
		output ready
	);
endinterface

### hw/rtl/shtv_out_if.sv
// ----------------------------------------------------------------------------
// HT frame velocity output channel
// Valid/ready channel carrying the clamped transform velocity.
// ----------------------------------------------------------------------------
interface shtv_out_if ();
	logic valid;
	logic ready;
	logic signed [shtv_pkg::OUT_BITS-1:0] ht_vx;
	logic signed [shtv_pkg::OUT_BITS-1:0] ht_vy;
	logic signed [shtv_pkg::OUT_BITS-1:0] ht_vz;
	logic clamped;

	modport source (output valid, ht_vx, ht_vy, ht_vz, clamped, input ready);
	modport sink (input valid, ht_vx, ht_vy, ht_vz, clamped, output ready);
endinterface

### hw/rtl/sim_to_ht_frame_velocity_unit.sv
// ----------------------------------------------------------------------------
// Simulation frame to de Hoffmann-Teller frame velocity
// Projection front end, three per-axis shift lanes and a merging output stage.
// ----------------------------------------------------------------------------
// The unit takes one item per clock and returns one result per item, in order.
// Most of its depth is the 42-step restoring divider in each axis lane, one
// quotient bit per stage. The pipeline only holds when the output register
// is full and not taken; bubbles ahead of a held result still close up, so
// input transfers go on until the pipe is full.
`include "sim_to_ht_frame_velocity_unit_assert.svh"

module sim_to_ht_frame_velocity_unit #(
	parameter int VEL_BITS = shtv_pkg::VEL_BITS_DEF,
	parameter int NFRAC    = shtv_pkg::NFRAC_DEF
) (
	input  logic clk,
	input  logic arst_n,
	shtv_in_if.sink   din,
	shtv_out_if.source dout,
	input  logic cfg_we,
	input  logic [shtv_pkg::CFG_IDX_BITS-1:0] cfg_idx,
	input  logic [shtv_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import shtv_pkg::*;

	localparam int SW  = VEL_BITS + 4;
	localparam int VHW = VEL_BITS + 7;
	localparam int NST = FRONT_LAT + LANE_LAT + 1;

	// configuration registers
	logic [MNF_BITS-1:0] min_normal_field_q;
	logic [LIM_BITS-1:0] speed_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_normal_field_q <= MNF_RESET;
			speed_limit_q <= LIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_MIN_NORMAL_FIELD: min_normal_field_q <= cfg_data[MNF_BITS-1:0];
				REG_SPEED_LIMIT:      speed_limit_q <= cfg_data[LIM_BITS-1:0];
				default: ;
			endcase
		end
	end

	// stage valids and stage enables, a stage moves when empty or its successor moves
	logic [NST-1:0] v_q;
	logic [NST-1:0] en;

	always_comb begin
		en[NST-1] = !v_q[NST-1] || dout.ready;
		for (int k = NST - 2; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= din.valid;
			for (int k = 1; k < NST; k++) begin
				if (en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	assign din.ready = en[0];

	// projection front end
	logic signed [VEL_BITS-1:0] pv [3], sv [3];
	logic signed [FIELD_BITS-1:0] fv [3];
	logic signed [NORM_BITS-1:0] nv [3];
	logic signed [VHW-1:0] vnh;
	logic signed [SW-1:0] snif [3];
	logic signed [BT_BITS-1:0] bt [3];
	logic [BN_BITS-1:0] den;
	logic den_neg;

	assign pv = '{din.plasma_vx, din.plasma_vy, din.plasma_vz};
	assign sv = '{din.shock_vx, din.shock_vy, din.shock_vz};
	assign fv = '{din.field_x, din.field_y, din.field_z};
	assign nv = '{din.normal_x, din.normal_y, din.normal_z};

	shtv_front #(
		.VEL_BITS(VEL_BITS),
		.NFRAC(NFRAC)
	) u_front (
		.clk(clk),
		.en(en[FRONT_LAT-1:0]),
		.plasma(pv),
		.shock(sv),
		.field(fv),
		.normal(nv),
		.min_normal_field(min_normal_field_q),
		.vnh(vnh),
		.snif(snif),
		.bt(bt),
		.den(den),
		.den_neg(den_neg)
	);

	// one shift lane per axis
	logic signed [OUT_BITS-1:0] ht [3];
	logic [2:0] clp;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		shtv_lane #(
			.VEL_BITS(VEL_BITS)
		) u_lane (
			.clk(clk),
			.en(en[FRONT_LAT +: LANE_LAT]),
			.vnh(vnh),
			.bt(bt[i]),
			.snif(snif[i]),
			.den(den),
			.den_neg(den_neg),
			.speed_limit(speed_limit_q),
			.ht(ht[i]),
			.clp(clp[i])
		);
	end

	// merge lanes into the output register
	logic signed [OUT_BITS-1:0] ht_vx_q, ht_vy_q, ht_vz_q;
	logic clamped_q;

	always_ff @(posedge clk) begin
		if (en[NST-1]) begin
			ht_vx_q <= ht[0];
			ht_vy_q <= ht[1];
			ht_vz_q <= ht[2];
			clamped_q <= |clp;
		end
	end

	assign dout.valid = v_q[NST-1];
	assign dout.ht_vx = ht_vx_q;
	assign dout.ht_vy = ht_vy_q;
	assign dout.ht_vz = ht_vz_q;
	assign dout.clamped = clamped_q;

	// checks
	`SHTV_ASSERT_NOW(a_ready_when_out_free, !v_q[NST-1] |-> din.ready, "input stalled with free output")
	`SHTV_ASSERT_NEXT(a_accept_enters_pipe, din.valid && din.ready, v_q[0], "accepted item lost at entry")
	`SHTV_ASSERT_NOW(a_out_within_limit, dout.valid |-> ($signed(dout.ht_vx) <= $signed({1'b0, speed_limit_q}) && $signed(dout.ht_vx) >= -$signed({1'b0, speed_limit_q})), "x result beyond speed limit")
	`SHTV_ASSERT_NOW(a_unclamped_z_ok, dout.valid && !dout.clamped |-> ($signed(dout.ht_vz) <= $signed({1'b0, speed_limit_q}) && $signed(dout.ht_vz) >= -$signed({1'b0, speed_limit_q})), "z result beyond limit without clamp flag")

endmodule

### hw/rtl/shtv_front.sv
// ----------------------------------------------------------------------------
// HT frame velocity projection front end
// Normal projections, NIF velocity, tangential field and clamped normal field.
// ----------------------------------------------------------------------------
module shtv_front #(
	parameter int VEL_BITS = shtv_pkg::VEL_BITS_DEF,
	parameter int NFRAC    = shtv_pkg::NFRAC_DEF
) (
	input  logic clk,
	input  logic [shtv_pkg::FRONT_LAT-1:0] en,
	input  logic signed [VEL_BITS-1:0] plasma [3],
	input  logic signed [VEL_BITS-1:0] shock [3],
	input  logic signed [shtv_pkg::FIELD_BITS-1:0] field [3],
	input  logic signed [shtv_pkg::NORM_BITS-1:0] normal [3],
	input  logic [shtv_pkg::MNF_BITS-1:0] min_normal_field,
	output logic signed [VEL_BITS+6:0] vnh,
	output logic signed [VEL_BITS+3:0] snif [3],
	output logic signed [shtv_pkg::BT_BITS-1:0] bt [3],
	output logic [shtv_pkg::BN_BITS-1:0] den,
	output logic den_neg
);
	import shtv_pkg::*;

	localparam int RW   = VEL_BITS + 1;
	localparam int NXW  = (NFRAC + 2 > NORM_BITS) ? NFRAC + 2 : NORM_BITS;
	localparam int PW   = RW + NXW;
	localparam int BPW  = FIELD_BITS + NXW;
	localparam int VNW  = VEL_BITS + 3;
	localparam int SW   = VEL_BITS + 4;
	localparam int WW   = VEL_BITS + 5;
	localparam int VHW  = VEL_BITS + 7;
	localparam int VNPW = VNW + NXW;
	localparam int BNPW = BN_BITS + NXW;
	localparam int WPW  = WW + NXW;

	localparam logic signed [NXW-1:0] N_ONE =
		{{(NXW-NFRAC-1){1'b0}}, 1'b1, {NFRAC{1'b0}}};
	localparam logic signed [NXW-1:0] N_MONE = -N_ONE;
	localparam logic signed [PW+1:0]  HALF_R  = (PW+2)'(1) << (NFRAC-1);
	localparam logic signed [BPW+1:0] HALF_B  = (BPW+2)'(1) << (NFRAC-1);
	localparam logic signed [VNPW:0]  HALF_VN = (VNPW+1)'(1) << (NFRAC-1);
	localparam logic signed [BNPW:0]  HALF_BN = (BNPW+1)'(1) << (NFRAC-1);
	localparam logic signed [WPW+1:0] HALF_W  = (WPW+2)'(1) << (NFRAC-1);

	// stage 1: saturated normal and relative velocity
	logic signed [NXW-1:0] n_s1 [3];
	logic signed [VEL_BITS-1:0] p_s1 [3], s_s1 [3];
	logic signed [RW-1:0] r_s1 [3];
	logic signed [FIELD_BITS-1:0] b_s1 [3];
	logic signed [NXW-1:0] nx [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nx[i] = NXW'(normal[i]);
			if (nx[i] > N_ONE) nx[i] = N_ONE;
			else if (nx[i] < N_MONE) nx[i] = N_MONE;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				n_s1[i] <= nx[i];
				p_s1[i] <= plasma[i];
				s_s1[i] <= shock[i];
				r_s1[i] <= RW'(plasma[i]) - RW'(shock[i]);
				b_s1[i] <= field[i];
			end
		end
	end

	// stage 2: products for normal velocity and normal field
	logic signed [PW-1:0] rn_s2 [3];
	logic signed [BPW-1:0] bp_s2 [3];
	logic signed [NXW-1:0] n_s2 [3];
	logic signed [VEL_BITS-1:0] p_s2 [3], s_s2 [3];
	logic signed [RW-1:0] r_s2 [3];
	logic signed [FIELD_BITS-1:0] b_s2 [3];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < 3; i++) begin
				rn_s2[i] <= r_s1[i] * n_s1[i];
				bp_s2[i] <= b_s1[i] * n_s1[i];
				n_s2[i] <= n_s1[i];
				p_s2[i] <= p_s1[i];
				s_s2[i] <= s_s1[i];
				r_s2[i] <= r_s1[i];
				b_s2[i] <= b_s1[i];
			end
		end
	end

	// stage 3: rounded dot products
	logic signed [PW+1:0] vn_sum;
	logic signed [BPW+1:0] bn_sum;
	logic signed [VNW-1:0] vn_s3;
	logic signed [BN_BITS-1:0] bn_s3;
	logic signed [NXW-1:0] n_s3 [3];
	logic signed [VEL_BITS-1:0] p_s3 [3], s_s3 [3];
	logic signed [RW-1:0] r_s3 [3];
	logic signed [FIELD_BITS-1:0] b_s3 [3];

	always_comb begin
		vn_sum = (PW+2)'(rn_s2[0]) + (PW+2)'(rn_s2[1]) + (PW+2)'(rn_s2[2]) + HALF_R;
		vn_sum = vn_sum >>> NFRAC;
		bn_sum = (BPW+2)'(bp_s2[0]) + (BPW+2)'(bp_s2[1]) + (BPW+2)'(bp_s2[2]) + HALF_B;
		bn_sum = bn_sum >>> NFRAC;
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			vn_s3 <= vn_sum[VNW-1:0];
			bn_s3 <= bn_sum[BN_BITS-1:0];
			for (int i = 0; i < 3; i++) begin
				n_s3[i] <= n_s2[i];
				p_s3[i] <= p_s2[i];
				s_s3[i] <= s_s2[i];
				r_s3[i] <= r_s2[i];
				b_s3[i] <= b_s2[i];
			end
		end
	end

	// stage 4: project the normal parts back onto each axis
	logic signed [VNPW-1:0] vnn_s4 [3];
	logic signed [BNPW-1:0] bnn_s4 [3];
	logic signed [NXW-1:0] n_s4 [3];
	logic signed [VEL_BITS-1:0] p_s4 [3], s_s4 [3];
	logic signed [RW-1:0] r_s4 [3];
	logic signed [FIELD_BITS-1:0] b_s4 [3];
	logic signed [BN_BITS-1:0] bn_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			bn_s4 <= bn_s3;
			for (int i = 0; i < 3; i++) begin
				vnn_s4[i] <= vn_s3 * n_s3[i];
				bnn_s4[i] <= bn_s3 * n_s3[i];
				n_s4[i] <= n_s3[i];
				p_s4[i] <= p_s3[i];
				s_s4[i] <= s_s3[i];
				r_s4[i] <= r_s3[i];
				b_s4[i] <= b_s3[i];
			end
		end
	end

	// stage 5: NIF velocity, tangential field, velocity relative to NIF
	logic signed [VNPW:0] vnr [3];
	logic signed [BNPW:0] bnr [3];
	logic signed [SW-1:0] sn [3];
	logic signed [SW-1:0] snif_s5 [3];
	logic signed [WW-1:0] w_s5 [3];
	logic signed [BT_BITS-1:0] bt_s5 [3];
	logic signed [NXW-1:0] n_s5 [3];
	logic signed [BN_BITS-1:0] bn_s5;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vnr[i] = ((VNPW+1)'(vnn_s4[i]) + HALF_VN) >>> NFRAC;
			bnr[i] = ((BNPW+1)'(bnn_s4[i]) + HALF_BN) >>> NFRAC;
			sn[i] = SW'(s_s4[i]) + SW'(r_s4[i]) - SW'($signed(vnr[i][VNW-1:0]));
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			bn_s5 <= bn_s4;
			for (int i = 0; i < 3; i++) begin
				snif_s5[i] <= sn[i];
				w_s5[i] <= WW'(p_s4[i]) - WW'(sn[i]);
				bt_s5[i] <= BT_BITS'(b_s4[i]) - BT_BITS'($signed(bnr[i][BN_BITS-1:0]));
				n_s5[i] <= n_s4[i];
			end
		end
	end

	// stage 6: products for normal speed in the NIF frame
	logic signed [WPW-1:0] wn_s6 [3];
	logic signed [SW-1:0] snif_s6 [3];
	logic signed [BT_BITS-1:0] bt_s6 [3];
	logic signed [BN_BITS-1:0] bn_s6;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			bn_s6 <= bn_s5;
			for (int i = 0; i < 3; i++) begin
				wn_s6[i] <= w_s5[i] * n_s5[i];
				snif_s6[i] <= snif_s5[i];
				bt_s6[i] <= bt_s5[i];
			end
		end
	end

	// stage 7: normal speed and floored normal field magnitude
	logic signed [WPW+1:0] vh_sum;
	logic [BN_BITS-1:0] flr, bmag;
	logic bneg;

	always_comb begin
		vh_sum = (WPW+2)'(wn_s6[0]) + (WPW+2)'(wn_s6[1]) + (WPW+2)'(wn_s6[2]) + HALF_W;
		vh_sum = vh_sum >>> NFRAC;
		flr = (min_normal_field == '0) ? BN_BITS'(1) : BN_BITS'(min_normal_field);
		bneg = bn_s6[BN_BITS-1];
		bmag = bneg ? BN_BITS'(-bn_s6) : BN_BITS'(bn_s6);
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			vnh <= vh_sum[VHW-1:0];
			den <= (bmag < flr) ? flr : bmag;
			den_neg <= bneg;
			for (int i = 0; i < 3; i++) begin
				snif[i] <= snif_s6[i];
				bt[i] <= bt_s6[i];
			end
		end
	end

endmodule

### hw/rtl/shtv_lane.sv
// ----------------------------------------------------------------------------
// HT frame velocity shift lane
// One axis: -vnh * bt / bc by pipelined restoring division, add and clamp.
// ----------------------------------------------------------------------------
module shtv_lane #(
	parameter int VEL_BITS = shtv_pkg::VEL_BITS_DEF
) (
	input  logic clk,
	input  logic [shtv_pkg::LANE_LAT-1:0] en,
	input  logic signed [VEL_BITS+6:0] vnh,
	input  logic signed [shtv_pkg::BT_BITS-1:0] bt,
	input  logic signed [VEL_BITS+3:0] snif,
	input  logic [shtv_pkg::BN_BITS-1:0] den,
	input  logic den_neg,
	input  logic [shtv_pkg::LIM_BITS-1:0] speed_limit,
	output logic signed [shtv_pkg::OUT_BITS-1:0] ht,
	output logic clp
);
	import shtv_pkg::*;

	localparam int SW    = VEL_BITS + 4;
	localparam int VHW   = VEL_BITS + 7;
	localparam int HIW   = VHW - MUL_SPLIT;
	localparam int NUMW  = VHW + BT_BITS;
	localparam int RA    = NUMW + 2;
	localparam int RB    = BN_BITS + CAP_BITS + 1;
	localparam int RMW   = ((RA > RB) ? RA : RB) + 1;
	localparam int D2W   = BN_BITS + 1;
	localparam int QW    = CAP_BITS + 1;
	localparam int VW    = ((SW > QW + 1) ? SW : QW + 1) + 1;
	localparam int NSTEP = CAP_BITS + 1;

	// stage 1: magnitudes and split product
	logic [VHW-1:0] vmag;
	logic [BT_BITS-1:0] tmag;
	logic [MUL_SPLIT+BT_BITS-1:0] pl_s1;
	logic [HIW+BT_BITS-1:0] ph_s1;
	logic [BN_BITS-1:0] den_s1;
	logic neg_s1;
	logic signed [SW-1:0] snif_s1;

	always_comb begin
		vmag = vnh[VHW-1] ? VHW'(-vnh) : VHW'(vnh);
		tmag = bt[BT_BITS-1] ? BT_BITS'(-bt) : BT_BITS'(bt);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			pl_s1 <= vmag[MUL_SPLIT-1:0] * tmag;
			ph_s1 <= vmag[VHW-1:MUL_SPLIT] * tmag;
			den_s1 <= den;
			neg_s1 <= ((vnh > 0) ^ bt[BT_BITS-1]) ^ den_neg;
			snif_s1 <= snif;
		end
	end

	// stage 2: rounding numerator and cap test
	logic [NUMW-1:0] num;
	logic [RMW-1:0] rem0;
	logic [D2W-1:0] d2;

	always_comb begin
		num = (NUMW'(ph_s1) << MUL_SPLIT) + NUMW'(pl_s1);
		d2 = {den_s1, 1'b0};
		rem0 = (RMW'(num) << 1) + RMW'(den_s1);
	end

	// divider pipe, element 0 is stage 2
	logic [RMW-1:0] drem [NSTEP+1];
	logic [QW-1:0] dq [NSTEP+1];
	logic [D2W-1:0] dd2 [NSTEP+1];
	logic dcap [NSTEP+1];
	logic dneg [NSTEP+1];
	logic signed [SW-1:0] dsn [NSTEP+1];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			drem[0] <= rem0;
			dq[0] <= '0;
			dd2[0] <= d2;
			dcap[0] <= (rem0 >= (RMW'(d2) << CAP_BITS));
			dneg[0] <= neg_s1;
			dsn[0] <= snif_s1;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar j = 0; j < NSTEP; j++) begin : g_div
		localparam int K = CAP_BITS - j;
		logic [RMW-1:0] trial;
		logic ge;

		always_comb begin
			trial = RMW'(dd2[j]) << K;
			ge = (drem[j] >= trial);
		end

		always_ff @(posedge clk) begin
			if (en[2+j]) begin
				drem[j+1] <= ge ? (drem[j] - trial) : drem[j];
				dq[j+1] <= dq[j] | (QW'(ge) << K);
				dd2[j+1] <= dd2[j];
				dcap[j+1] <= dcap[j];
				dneg[j+1] <= dneg[j];
				dsn[j+1] <= dsn[j];
			end
		end
	end

	// last stage: apply sign, add to NIF velocity, clamp
	logic [QW-1:0] qf;
	logic signed [QW:0] shf;
	logic signed [VW-1:0] vsum, lim_p, lim_n, vcl;
	logic over;

	always_comb begin
		qf = dcap[NSTEP] ? (QW'(1) << CAP_BITS) : dq[NSTEP];
		shf = dneg[NSTEP] ? -$signed({1'b0, qf}) : $signed({1'b0, qf});
		vsum = VW'(dsn[NSTEP]) + VW'(shf);
		lim_p = VW'($signed({1'b0, speed_limit}));
		lim_n = -lim_p;
		over = 1'b1;
		if (vsum > lim_p) vcl = lim_p;
		else if (vsum < lim_n) vcl = lim_n;
		else begin
			vcl = vsum;
			over = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[LANE_LAT-1]) begin
			ht <= vcl[OUT_BITS-1:0];
			clp <= over;
		end
	end

endmodule
